FILE: rtl/msdm_pkg.sv
// Package for the multi-stream deadline monitor: sizes, action codes,
// register addresses and the types shared by the front, queue and back.
// No dependencies.
package msdm_pkg;

    localparam int STREAMS = 16;
    localparam int IDX_W   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int MAX_OUT = 16;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    localparam int ACT_W   = 3;
    localparam int SLOT_W  = 4;
    localparam int ID_W    = 64;
    localparam int DL_W    = 32;
    localparam int TIME_W  = 48;
    localparam int POLL_W  = 16;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 72;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [DL_W-1:0]   DEFAULT_DEADLINE_RST = 32'd50;
    localparam logic [POLL_W-1:0] POLL_INTERVAL_RST    = 16'd5;

    // Input action codes.
    localparam logic [ACT_W-1:0] ACT_LOAD      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_HEARTBEAT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_OVERFLOW  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TICK      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY     = 3'd4;

    // Register select, taken from address bit 2.
    localparam logic REG_DEFAULT_DEADLINE = 1'b0;
    localparam logic REG_POLL_INTERVAL    = 1'b1;

    typedef enum logic [2:0] {
        K_LOAD,
        K_HEARTBEAT,
        K_OVERFLOW,
        K_TICK,
        K_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    id;
        logic [DL_W-1:0]    deadline;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic              is_event;
        logic              found;
        logic              changed;
        logic              alive_now;
        logic [ID_W-1:0]   stream;
        logic              last;
    } result_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MATCH,
        B_EXEC,
        B_SWEEP,
        B_FLUSH
    } back_state_t;

endpackage

FILE: rtl/multi_stream_deadline_monitor_unit.sv
// Top level of the multi-stream deadline monitor: configuration registers,
// front end, command queue and back end. Depends on msdm_pkg and all msdm_* modules.
//
//   channel   kind          content
//   s_*       stream in     commands: load, heartbeat, overflow, tick, query
//   m_*       stream out    command replies and dead events from sweeps
//   p*        APB slave     default deadline (0x0), poll interval (0x4)
//
// Load executes directly; heartbeat, overflow and query match the table, then update.
// A tick without a sweep is handled in idle; a sweeping tick scans the slots one per
// cycle, pausing while the result register is held, then flushes the pending event.
// The two-entry queue lets the front accept while the back is busy.
// Reset clears the slot flags, the clock and poll counter; stored ids need none.
// A stalled result holds in the output register and stops the back only when needed.
module multi_stream_deadline_monitor_unit
    import msdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata: slot[3:0], stream[67:4], deadline[99:68], zero fill [103:100]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: action[2:0]
    input  logic [ACT_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: found[0], changed[1], alive_now[2], event_stream[66:3], zero fill [71:67]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // m_tuser: is_event[0]
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    logic [DL_W-1:0]   cfg_deadline_reg;
    logic [POLL_W-1:0] cfg_poll_reg;
    logic              cfg_write;

    q_status_t         q_status;
    logic              q_push, q_pop;
    cmd_t              q_in_cmd, q_out_cmd;
    result_t           res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_deadline_reg <= DEFAULT_DEADLINE_RST;
            cfg_poll_reg     <= POLL_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_DEFAULT_DEADLINE: cfg_deadline_reg <= pwdata[DL_W-1:0];
                REG_POLL_INTERVAL:    cfg_poll_reg     <= pwdata[POLL_W-1:0];
                default:              cfg_poll_reg     <= cfg_poll_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DEFAULT_DEADLINE: prdata = PDATA_W'(cfg_deadline_reg);
            REG_POLL_INTERVAL:    prdata = PDATA_W'(cfg_poll_reg);
            default:              prdata = '0;
        endcase
    end

    msdm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    msdm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_out_cmd),
        .status   (q_status)
    );

    msdm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .default_deadline (cfg_deadline_reg),
        .poll_interval    (cfg_poll_reg),
        .q_status         (q_status),
        .q_cmd            (q_out_cmd),
        .q_pop            (q_pop),
        .res_valid        (m_tvalid),
        .res_ready        (m_tready),
        .res              (res)
    );

    assign m_tdata = {{(OUT_DATA_W - ID_W - 3){1'b0}}, res.stream,
                      res.alive_now, res.changed, res.found};
    assign m_tuser = res.is_event;
    assign m_tlast = res.last;

endmodule

FILE: rtl/msdm_queue.sv
// Short command queue between the front and the back of the deadline monitor.
// Depends on msdm_pkg for the command type and depth.
module msdm_queue
    import msdm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      pop_cmd,
    output q_status_t status
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd      = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign status.empty = (count_reg == '0);

endmodule

FILE: rtl/msdm_front.sv
// Front end of the deadline monitor: takes input items, decodes the action
// and queues known commands. Depends on msdm_pkg.
module msdm_front
    import msdm_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [ACT_W-1:0]     s_tuser,
    input  q_status_t            q_status,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic known;

    always_comb
    begin
        known          = 1'b1;
        q_cmd.kind     = K_LOAD;
        q_cmd.slot     = s_tdata[SLOT_W-1:0];
        q_cmd.id       = s_tdata[SLOT_W+ID_W-1:SLOT_W];
        q_cmd.deadline = s_tdata[SLOT_W+ID_W+DL_W-1:SLOT_W+ID_W];
        unique case (s_tuser)
            ACT_LOAD:      q_cmd.kind = K_LOAD;
            ACT_HEARTBEAT: q_cmd.kind = K_HEARTBEAT;
            ACT_OVERFLOW:  q_cmd.kind = K_OVERFLOW;
            ACT_TICK:      q_cmd.kind = K_TICK;
            ACT_QUERY:     q_cmd.kind = K_QUERY;
            default:       known      = 1'b0;
        endcase
    end

    // Unknown actions are accepted and dropped here; they cause no result.
    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && s_tready && known;

endmodule

FILE: rtl/msdm_back.sv
// Back end of the deadline monitor: slot table, millisecond clock, poll
// counter, command execution, deadline sweep and the result register.
// Depends on msdm_pkg.
module msdm_back
    import msdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DL_W-1:0]   default_deadline,
    input  logic [POLL_W-1:0] poll_interval,
    input  q_status_t         q_status,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [STREAMS-1:0]  hit_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [POLL_W-1:0]   poll_reg, poll_next;

    logic [STREAMS-1:0]  valid_reg, alive_reg, rep_reg;
    logic [ID_W-1:0]     id_mem   [STREAMS];
    logic [DL_W-1:0]     dl_mem   [STREAMS];
    logic [TIME_W-1:0]   seen_mem [STREAMS];

    result_t             out_reg;
    logic                out_valid_reg;

    logic                can_push, push;
    result_t             push_res;

    logic                ld_we, seen_we, flg_we;
    logic [IDX_W-1:0]    ld_idx, seen_idx, flg_idx;
    logic                flg_alive, flg_rep;

    logic [IDX_W-1:0]    hit_idx;
    logic                hit_any;
    logic [STREAMS-1:0]  match_vec;
    logic [8:0]          slot_ext;
    logic                slot_ok;
    logic [DL_W-1:0]     eff_deadline;
    logic [TIME_W:0]     sw_diff;
    logic [TIME_W-1:0]   sw_elapsed;
    logic                sw_due;
    logic [POLL_W-1:0]   period;
    logic [POLL_W-1:0]   poll_inc;

    assign can_push = !out_valid_reg || res_ready;

    always_comb
    begin
        for (int i = 0; i < STREAMS; i++)
        begin
            match_vec[i] = valid_reg[i] && (id_mem[i] == cmd_reg.id);
        end
    end

    // Lowest matching slot wins.
    always_comb
    begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = STREAMS - 1; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                hit_idx = IDX_W'(i);
                hit_any = 1'b1;
            end
        end
    end

    assign slot_ext     = 9'(cmd_reg.slot);
    assign slot_ok      = slot_ext < 9'(STREAMS);
    assign eff_deadline = (cmd_reg.deadline != '0) ? cmd_reg.deadline : default_deadline;

    assign sw_diff    = {1'b0, time_reg} - {1'b0, seen_mem[idx_reg]};
    assign sw_elapsed = sw_diff[TIME_W] ? '0 : sw_diff[TIME_W-1:0];
    assign sw_due     = valid_reg[idx_reg]
                        && (sw_elapsed >= TIME_W'(dl_mem[idx_reg]))
                        && (alive_reg[idx_reg] || !rep_reg[idx_reg])
                        && (cnt_reg < CNT_W'(MAX_OUT));

    assign period   = (poll_interval == '0) ? POLL_W'(1) : poll_interval;
    assign poll_inc = poll_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        cnt_next        = cnt_reg;
        time_next       = time_reg;
        poll_next       = poll_reg;
        q_pop           = 1'b0;
        push            = 1'b0;
        push_res        = '0;
        ld_we           = 1'b0;
        ld_idx          = slot_ext[IDX_W-1:0];
        seen_we         = 1'b0;
        seen_idx        = hit_idx;
        flg_we          = 1'b0;
        flg_idx         = hit_idx;
        flg_alive       = 1'b0;
        flg_rep         = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.kind)
                        K_LOAD:
                        begin
                            state_next = B_EXEC;
                        end
                        K_TICK:
                        begin
                            if (time_reg != TIME_MAX)
                            begin
                                time_next = time_reg + 1'b1;
                            end
                            if (poll_inc >= period)
                            begin
                                poll_next       = '0;
                                idx_next        = '0;
                                pend_valid_next = 1'b0;
                                cnt_next        = '0;
                                state_next      = B_SWEEP;
                            end
                            else
                            begin
                                poll_next = poll_inc;
                            end
                        end
                        default:
                        begin
                            state_next = B_MATCH;
                        end
                    endcase
                end
            end

            B_MATCH:
            begin
                state_next = B_EXEC;
            end

            B_EXEC:
            begin
                if (can_push)
                begin
                    push            = 1'b1;
                    push_res.stream = cmd_reg.id;
                    push_res.last   = 1'b1;
                    state_next      = B_IDLE;
                    case (cmd_reg.kind)
                        K_LOAD:
                        begin
                            if (slot_ok)
                            begin
                                push_res.found = 1'b1;
                                ld_we          = 1'b1;
                                seen_we        = 1'b1;
                                seen_idx       = slot_ext[IDX_W-1:0];
                                flg_we         = 1'b1;
                                flg_idx        = slot_ext[IDX_W-1:0];
                            end
                        end
                        K_HEARTBEAT:
                        begin
                            if (hit_any)
                            begin
                                push_res.found     = 1'b1;
                                push_res.alive_now = 1'b1;
                                seen_we            = 1'b1;
                                if (!alive_reg[hit_idx])
                                begin
                                    push_res.changed = 1'b1;
                                    flg_we           = 1'b1;
                                    flg_alive        = 1'b1;
                                    flg_rep          = 1'b1;
                                end
                            end
                        end
                        K_OVERFLOW:
                        begin
                            if (hit_any)
                            begin
                                push_res.found = 1'b1;
                                if (alive_reg[hit_idx] || !rep_reg[hit_idx])
                                begin
                                    push_res.changed = 1'b1;
                                    flg_we           = 1'b1;
                                    flg_rep          = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (hit_any)
                            begin
                                push_res.found     = 1'b1;
                                push_res.alive_now = alive_reg[hit_idx];
                            end
                        end
                    endcase
                end
            end

            B_SWEEP:
            begin
                // An event is held back one slot so that the final one can carry last.
                if (!(sw_due && pend_valid_reg && !can_push))
                begin
                    if (sw_due)
                    begin
                        if (pend_valid_reg)
                        begin
                            push              = 1'b1;
                            push_res.is_event = 1'b1;
                            push_res.found    = 1'b1;
                            push_res.changed  = 1'b1;
                            push_res.stream   = pend_id_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = id_mem[idx_reg];
                        cnt_next        = cnt_reg + 1'b1;
                        flg_we          = 1'b1;
                        flg_idx         = idx_reg;
                        flg_rep         = 1'b1;
                    end
                    if (idx_reg == IDX_W'(STREAMS - 1))
                    begin
                        state_next = B_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            B_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = B_IDLE;
                end
                else if (can_push)
                begin
                    push              = 1'b1;
                    push_res.is_event = 1'b1;
                    push_res.found    = 1'b1;
                    push_res.changed  = 1'b1;
                    push_res.stream   = pend_id_reg;
                    push_res.last     = 1'b1;
                    pend_valid_next   = 1'b0;
                    state_next        = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            time_reg       <= '0;
            poll_reg       <= '0;
            valid_reg      <= '0;
            alive_reg      <= '0;
            rep_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            time_reg       <= time_next;
            poll_reg       <= poll_next;
            if (ld_we)
            begin
                valid_reg[ld_idx] <= 1'b1;
            end
            if (flg_we)
            begin
                alive_reg[flg_idx] <= flg_alive;
                rep_reg[flg_idx]   <= flg_rep;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        pend_id_reg <= pend_id_next;
        hit_reg     <= match_vec;
        if (ld_we)
        begin
            id_mem[ld_idx] <= cmd_reg.id;
            dl_mem[ld_idx] <= eff_deadline;
        end
        if (seen_we)
        begin
            seen_mem[seen_idx] <= time_reg;
        end
        if (push)
        begin
            out_reg <= push_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> can_push)
        else $error("result register overwritten while still held");

    a_match_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_MATCH) |=> (state_reg == B_EXEC))
        else $error("lookup did not proceed to execution");

    a_event_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_res.is_event) |-> (state_reg == B_SWEEP || state_reg == B_FLUSH))
        else $error("dead event produced outside a sweep");

    a_event_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_OUT))
        else $error("sweep produced more events than allowed");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("command popped from an empty queue");

endmodule
